### rtl/core/password_door_lock_controller_unit_macros.svh
// assertion macros shared by the door lock controller rtl
`ifndef PASSWORD_DOOR_LOCK_CONTROLLER_UNIT_MACROS_SVH
`define PASSWORD_DOOR_LOCK_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define PDLC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pdlc same-cycle check failed");

// next-cycle implication, checked while out of reset
`define PDLC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pdlc next-cycle check failed");

`endif

### rtl/core/pdlc_pkg.sv
// shared types and constants of the door lock controller
package pdlc_pkg;

    // input kinds carried on s_tuser
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // command characters
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // motor drive codes
    localparam logic [1:0] MOTOR_STOP = 2'd0;
    localparam logic [1:0] MOTOR_CW   = 2'd1;
    localparam logic [1:0] MOTOR_ACW  = 2'd2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FAILURES = 3'd4;

    // register reset values
    localparam logic [7:0] OPEN_TICKS_RST   = 8'd15;
    localparam logic [7:0] HOLD_TICKS_RST   = 8'd3;
    localparam logic [7:0] CLOSE_TICKS_RST  = 8'd15;
    localparam logic [7:0] ALARM_TICKS_RST  = 8'd60;
    localparam logic [3:0] MAX_FAILURES_RST = 4'd3;

    // failure count saturation
    localparam logic [3:0] FAIL_SAT = 4'd15;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    // send counts of one request
    localparam logic [1:0] NSEND_NONE = 2'd0;
    localparam logic [1:0] NSEND_ONE  = 2'd1;
    localparam logic [1:0] NSEND_TWO  = 2'd2;

    // all results of one request
    typedef struct packed {
        logic [1:0] nsend;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [1:0] motor;
        logic       buzz;
    } pdlc_entry_t;

endpackage

### rtl/core/pdlc_result_queue.sv
// two-entry result queue that splits each entry into one or two output results
module pdlc_result_queue (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               push,
    input  pdlc_pkg::pdlc_entry_t              push_entry,
    output logic                               full,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pdlc_pkg::M_TDATA_W-1:0]     m_tdata,   // send_byte[7:0], motor_drive[9:8], alarm_on[10], zero
    output logic                               m_tuser,   // send_valid
    output logic                               m_tlast
);
    import pdlc_pkg::*;

    pdlc_entry_t entry_reg [2];
    logic        head_reg, head_next;
    logic        tail_reg, tail_next;
    logic [1:0]  count_reg, count_next;
    logic        part_reg, part_next;
    pdlc_entry_t head_entry;
    logic        two_sends;
    logic        pop;
    logic        out_fire;
    logic [7:0]  send_byte;

    // head entry decode
    assign head_entry = entry_reg[head_reg];
    assign two_sends  = head_entry.nsend == NSEND_TWO;
    assign m_tvalid   = count_reg != 2'd0;
    assign m_tlast    = !two_sends || part_reg;
    assign m_tuser    = head_entry.nsend != NSEND_NONE;
    assign send_byte  = part_reg ? head_entry.byte1 : head_entry.byte0;
    assign m_tdata    = {5'd0, head_entry.buzz, head_entry.motor, send_byte};
    assign full       = count_reg == 2'd2;

    // pointer and count update
    assign out_fire = m_tvalid && m_tready;
    assign pop      = out_fire && m_tlast;

    always_comb begin
        head_next  = pop ? ~head_reg : head_reg;
        tail_next  = push ? ~tail_reg : tail_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
        part_next  = out_fire ? !m_tlast : part_reg;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
            part_reg  <= 1'b0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            part_reg  <= part_next;
        end
    end

    // payload storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[tail_reg] <= push_entry;
        end
    end

endmodule

### rtl/core/password_door_lock_controller_unit.sv
// top level of the door lock controller
// results of a request are registered in the result queue; a request with two results holds
// the output until both are taken; throughput: one request per cycle while the queue is not full
// the password bytes sit in one memory of two banks, read into a register ahead of each byte
// reset: synchronous active-low aresetn returns to password setup, registers to defaults
`include "password_door_lock_controller_unit_macros.svh"

module password_door_lock_controller_unit #(
    parameter int PASS_LEN = 5
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pdlc_pkg::S_TDATA_W-1:0]     s_tdata,   // data_byte[7:0]
    input  logic                               s_tuser,   // cmd
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pdlc_pkg::M_TDATA_W-1:0]     m_tdata,   // send_byte[7:0], motor_drive[9:8], alarm_on[10], zero
    output logic                               m_tuser,   // send_valid
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [pdlc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdlc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pdlc_pkg::*;

    localparam int IDX_W     = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;
    localparam int ADDR_W    = IDX_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam logic [IDX_W:0] LAST_IDX = (IDX_W + 1)'(PASS_LEN - 1);

    typedef enum logic [3:0] {
        PH_SETUP_FIRST   = 4'd0,
        PH_SETUP_CONFIRM = 4'd1,
        PH_IDLE          = 4'd2,
        PH_OPEN_ENTRY    = 4'd3,
        PH_CHG_VERIFY    = 4'd4,
        PH_CHG_FIRST     = 4'd5,
        PH_CHG_CONFIRM   = 4'd6,
        PH_MOTOR_CW      = 4'd7,
        PH_HOLD          = 4'd8,
        PH_MOTOR_ACW     = 4'd9,
        PH_ALARM         = 4'd10
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               match_reg, match_next;
    logic [3:0]         fail_reg, fail_next;
    logic [7:0]         tick_reg, tick_next;
    logic               bank_reg, bank_next;
    logic [7:0]         open_ticks_reg;
    logic [7:0]         hold_ticks_reg;
    logic [7:0]         close_ticks_reg;
    logic [7:0]         alarm_ticks_reg;
    logic [3:0]         max_fail_reg;

    logic [7:0]         pass_mem [MEM_DEPTH];
    logic [7:0]         rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               wr_en;
    logic               rd_bank;

    logic               accept;
    logic               is_tick;
    logic [7:0]         in_byte;
    logic               idx_last;
    logic [IDX_W-1:0]   idx_inc;
    logic               match_now;
    logic [3:0]         fail_inc;
    logic               fail_alarm;
    logic [7:0]         tick_limit;
    logic               tick_done;
    logic               q_full;
    pdlc_entry_t        q_entry;

    // input handshake
    assign s_tready = aresetn && !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_tick  = s_tuser == CMD_TICK;
    assign in_byte  = s_tdata;

    // byte position and running compare
    assign idx_last  = {1'b0, idx_reg} >= LAST_IDX;
    assign idx_inc   = idx_last ? '0 : idx_reg + 1'b1;
    assign match_now = (idx_reg == '0) ? (rd_data_reg == in_byte)
                                       : (match_reg && (rd_data_reg == in_byte));

    // failure counting
    assign fail_inc   = (fail_reg == FAIL_SAT) ? FAIL_SAT : fail_reg + 4'd1;
    assign fail_alarm = fail_inc >= max_fail_reg;

    // tick limit of the timed phase
    always_comb begin
        case (phase_reg)
            PH_MOTOR_CW:  tick_limit = open_ticks_reg;
            PH_HOLD:      tick_limit = hold_ticks_reg;
            PH_MOTOR_ACW: tick_limit = close_ticks_reg;
            default:      tick_limit = alarm_ticks_reg;
        endcase
    end
    assign tick_done = ({1'b0, tick_reg} + 9'd1) >= {1'b0, tick_limit};

    // next state and results of one request
    always_comb begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        match_next    = match_reg;
        fail_next     = fail_reg;
        tick_next     = tick_reg;
        bank_next     = bank_reg;
        wr_en         = 1'b0;
        q_entry.nsend = NSEND_NONE;
        q_entry.byte0 = 8'd0;
        q_entry.byte1 = 8'd0;
        if (accept) begin
            if (is_tick) begin
                case (phase_reg)
                    PH_MOTOR_CW, PH_HOLD, PH_MOTOR_ACW, PH_ALARM: begin
                        if (tick_done) begin
                            tick_next = 8'd0;
                            case (phase_reg)
                                PH_MOTOR_CW:  phase_next = PH_HOLD;
                                PH_HOLD:      phase_next = PH_MOTOR_ACW;
                                default:      phase_next = PH_IDLE;
                            endcase
                        end else begin
                            tick_next = tick_reg + 8'd1;
                        end
                    end
                    PH_SETUP_FIRST, PH_SETUP_CONFIRM, PH_IDLE, PH_OPEN_ENTRY,
                    PH_CHG_VERIFY, PH_CHG_FIRST, PH_CHG_CONFIRM: begin
                    end
                    default: begin
                        idx_next   = '0;
                        phase_next = PH_IDLE;
                    end
                endcase
            end else begin
                case (phase_reg)
                    PH_SETUP_FIRST, PH_CHG_FIRST: begin
                        wr_en    = 1'b1;
                        idx_next = idx_inc;
                        if (idx_last) begin
                            phase_next = (phase_reg == PH_SETUP_FIRST) ? PH_SETUP_CONFIRM
                                                                       : PH_CHG_CONFIRM;
                        end
                    end
                    PH_SETUP_CONFIRM, PH_CHG_CONFIRM: begin
                        idx_next   = idx_inc;
                        match_next = match_now;
                        if (idx_last) begin
                            q_entry.nsend = NSEND_ONE;
                            q_entry.byte0 = {7'd0, match_now};
                            if (match_now) begin
                                bank_next  = ~bank_reg;
                                phase_next = PH_IDLE;
                            end else begin
                                phase_next = (phase_reg == PH_SETUP_CONFIRM) ? PH_SETUP_FIRST
                                                                             : PH_IDLE;
                            end
                        end
                    end
                    PH_IDLE: begin
                        idx_next = '0;
                        if (in_byte == CHAR_PLUS) begin
                            phase_next = PH_OPEN_ENTRY;
                        end else if (in_byte == CHAR_MINUS) begin
                            phase_next = PH_CHG_VERIFY;
                        end
                    end
                    PH_OPEN_ENTRY, PH_CHG_VERIFY: begin
                        idx_next   = idx_inc;
                        match_next = match_now;
                        if (idx_last) begin
                            q_entry.byte0 = {7'd0, match_now};
                            if (match_now) begin
                                q_entry.nsend = NSEND_ONE;
                                fail_next     = 4'd0;
                                if (phase_reg == PH_OPEN_ENTRY) begin
                                    tick_next  = 8'd0;
                                    phase_next = PH_MOTOR_CW;
                                end else begin
                                    phase_next = PH_CHG_FIRST;
                                end
                            end else begin
                                // wrong password: flag then failure count
                                q_entry.nsend = NSEND_TWO;
                                q_entry.byte1 = {4'd0, fail_inc};
                                if (fail_alarm) begin
                                    fail_next  = 4'd0;
                                    tick_next  = 8'd0;
                                    phase_next = PH_ALARM;
                                end else begin
                                    fail_next  = fail_inc;
                                    phase_next = PH_IDLE;
                                end
                            end
                        end
                    end
                    PH_MOTOR_CW, PH_HOLD, PH_MOTOR_ACW, PH_ALARM: begin
                    end
                    default: begin
                        idx_next   = '0;
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
        q_entry.motor = (phase_next == PH_MOTOR_CW)  ? MOTOR_CW  :
                        (phase_next == PH_MOTOR_ACW) ? MOTOR_ACW : MOTOR_STOP;
        q_entry.buzz  = phase_next == PH_ALARM;
    end

    // confirm phases read the entry bank, the others the stored bank
    assign rd_bank = ((phase_next == PH_SETUP_CONFIRM) || (phase_next == PH_CHG_CONFIRM))
                     ? ~bank_next : bank_next;
    assign rd_addr = {rd_bank, idx_next};
    assign wr_addr = {~bank_reg, idx_reg};

    // password memory with write-to-read forwarding
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pass_mem[wr_addr] <= in_byte;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= in_byte;
        end else begin
            rd_data_reg <= pass_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SETUP_FIRST;
            idx_reg   <= '0;
            match_reg <= 1'b1;
            fail_reg  <= 4'd0;
            tick_reg  <= 8'd0;
            bank_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            match_reg <= match_next;
            fail_reg  <= fail_next;
            tick_reg  <= tick_next;
            bank_reg  <= bank_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_ticks_reg  <= OPEN_TICKS_RST;
            hold_ticks_reg  <= HOLD_TICKS_RST;
            close_ticks_reg <= CLOSE_TICKS_RST;
            alarm_ticks_reg <= ALARM_TICKS_RST;
            max_fail_reg    <= MAX_FAILURES_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_OPEN_TICKS:   open_ticks_reg  <= cfg_data;
                REG_HOLD_TICKS:   hold_ticks_reg  <= cfg_data;
                REG_CLOSE_TICKS:  close_ticks_reg <= cfg_data;
                REG_ALARM_TICKS:  alarm_ticks_reg <= cfg_data;
                REG_MAX_FAILURES: max_fail_reg    <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // result queue
    pdlc_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_entry (q_entry),
        .full       (q_full),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // assertions
    `PDLC_ASSERT_NEXT(a_alarm_ignores_bytes, aclk, aresetn, accept && !is_tick && (phase_reg == PH_ALARM), phase_reg == PH_ALARM)
    `PDLC_ASSERT_SAME(a_idx_clear_when_waiting, aclk, aresetn, (phase_reg == PH_IDLE) || (phase_reg == PH_ALARM), idx_reg == '0)
    `PDLC_ASSERT_NEXT(a_bank_flips_on_confirm, aclk, aresetn, !(accept && !is_tick && ((phase_reg == PH_SETUP_CONFIRM) || (phase_reg == PH_CHG_CONFIRM))), $stable(bank_reg))
    `PDLC_ASSERT_SAME(a_buzzer_motor_apart, aclk, aresetn, accept && q_entry.buzz, q_entry.motor == MOTOR_STOP)

endmodule
